[sv/cfd_pkg.sv]
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types for the COBS frame decoder: result kinds and the result item.
// ----------------------------------------------------------------------------
package cfd_pkg;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_END      = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
  } result_t;

endpackage

[sv/cfd_in_reg.sv]
// ----------------------------------------------------------------------------
// cfd_in_reg
// Input register: holds one received byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module cfd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic load;

  // free the register in the same cycle the held item moves on
  assign in_stall = held_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_byte <= in_byte;
    end
  end

endmodule

[sv/cfd_decode.sv]
// ----------------------------------------------------------------------------
// cfd_decode
// Frame state and the single-pass decode of one byte into one result item.
// ----------------------------------------------------------------------------
module cfd_decode
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] cur_byte,
  input  logic [7:0] max_length,
  output result_t    res
);

  logic       collecting;
  logic [7:0] byte_count;
  logic [7:0] zero_distance;
  logic       collecting_next;
  logic [7:0] byte_count_next;
  logic [7:0] zero_distance_next;
  logic [7:0] dist_dec;

  assign dist_dec = zero_distance - 8'd1;

  always_comb begin
    collecting_next    = collecting;
    byte_count_next    = byte_count;
    zero_distance_next = zero_distance;
    res.kind           = KIND_NONE;
    res.data_byte      = 8'd0;
    res.byte_index     = 8'd0;
    res.frame_length   = 8'd0;
    if (cur_byte == 8'd0) begin
      // delimiter: report length and start over
      res.kind           = KIND_END;
      res.frame_length   = byte_count;
      collecting_next    = 1'b0;
      byte_count_next    = 8'd0;
      zero_distance_next = 8'd0;
    end else if (!collecting) begin
      collecting_next    = 1'b1;
      zero_distance_next = cur_byte;
    end else if (byte_count >= max_length) begin
      // drop the frame; this byte is not a code byte
      res.kind           = KIND_OVERFLOW;
      collecting_next    = 1'b0;
      byte_count_next    = 8'd0;
      zero_distance_next = 8'd0;
    end else begin
      res.kind        = KIND_DATA;
      res.byte_index  = byte_count;
      byte_count_next = byte_count + 8'd1;
      if (dist_dec == 8'd0) begin
        res.data_byte      = 8'd0;
        zero_distance_next = cur_byte;
      end else begin
        res.data_byte      = cur_byte;
        zero_distance_next = dist_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting    <= 1'b0;
      byte_count    <= 8'd0;
      zero_distance <= 8'd0;
    end else if (advance) begin
      collecting    <= collecting_next;
      byte_count    <= byte_count_next;
      zero_distance <= zero_distance_next;
    end
  end

endmodule

[sv/cobs_frame_decoder.sv]
// ----------------------------------------------------------------------------
// cobs_frame_decoder
// COBS decoder that takes one encoded byte per item and gives one result each.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle with no bubbles while out_stall is low; every
// accepted byte gives exactly one result item (kind none, data, frame end or
// overflow drop). The byte sits in an input register, is decoded against the
// frame state, and lands in the result register. The frame state update
// (compare with max_length, countdown, count increment) is the one loop that
// sets the rate. max_length resets to 255. Write it (cfg_wr_en/cfg_wr_data)
// only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module cobs_frame_decoder
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [7:0] byte_index,
  output logic [7:0] frame_length
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;
  logic [7:0] max_length;
  result_t    res;
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= 8'd255;
    end else if (cfg_wr_en) begin
      max_length <= cfg_wr_data;
    end
  end

  // move the held item on whenever the result register is free or draining
  assign advance = held_valid && (!out_valid || !out_stall);

  cfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .take       (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  cfd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .cur_byte   (held_byte),
    .max_length (max_length),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign kind         = out_res.kind;
  assign data_byte    = out_res.data_byte;
  assign byte_index   = out_res.byte_index;
  assign frame_length = out_res.frame_length;

endmodule
